// ===== design/top_k_magnitude_selector_defines.svh =====
// assertion macros shared by the top-k magnitude selector rtl
// no dependencies; included by files that carry concurrent checks
`ifndef TOP_K_MAGNITUDE_SELECTOR_DEFINES_SVH
`define TOP_K_MAGNITUDE_SELECTOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TKMS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, disabled in reset
`define TKMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== design/tkms_pkg.sv =====
// package of the top-k magnitude selector: widths, defaults, register map
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package tkms_pkg;

    localparam int MAG_W        = 63;
    localparam int OUT_TAG_W    = 20;
    localparam int IN_TAG_W     = 20;
    localparam int RANK_W       = 6;
    localparam int TAKE_W       = 7;
    localparam int DEF_CAPACITY = 64;
    localparam int DEF_TAG_BITS = 20;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [0:0]        REG_TAKE_COUNT = 1'b0;
    localparam logic [TAKE_W-1:0] TAKE_RESET     = 7'd1;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/tkms_if.sv =====
// valid/ready channel interfaces for entry words and result words
// depends on tkms_pkg
`default_nettype none

interface tkms_in_if import tkms_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MAG_W-1:0]     magnitude;
    logic [IN_TAG_W-1:0]  column_tag;
    logic                 last_entry;

    modport source (output valid, magnitude, column_tag, last_entry, input ready);
    modport sink   (input valid, magnitude, column_tag, last_entry, output ready);
endinterface

interface tkms_out_if import tkms_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_TAG_W-1:0] column_out;
    logic [MAG_W-1:0]     magnitude_out;
    logic [RANK_W-1:0]    rank;
    logic                 last_result;
    logic                 overflow;

    modport source (output valid, column_out, magnitude_out, rank, last_result, overflow,
                    input ready);
    modport sink   (input valid, column_out, magnitude_out, rank, last_result, overflow,
                    output ready);
endinterface

`default_nettype wire

// ===== design/tkms_cell.sv =====
// one insertion cell of the sorted chain: holds a magnitude and its tag
// depends on tkms_pkg
`default_nettype none

module tkms_cell import tkms_pkg::*; #(
    parameter int TAG_BITS = DEF_TAG_BITS
) (
    input  wire logic                clk,
    input  wire cell_ctl_t           ctl,
    input  wire logic                occupied,
    input  wire logic [MAG_W-1:0]    new_mag,
    input  wire logic [TAG_BITS-1:0] new_tag,
    input  wire logic                prev_lt,
    input  wire logic [MAG_W-1:0]    prev_mag,
    input  wire logic [TAG_BITS-1:0] prev_tag,
    input  wire logic [MAG_W-1:0]    next_mag,
    input  wire logic [TAG_BITS-1:0] next_tag,
    output logic                     lt,
    output logic [MAG_W-1:0]         mag,
    output logic [TAG_BITS-1:0]      tag
);

    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;

    // strictly smaller or empty: the new word goes at or above this cell
    assign lt  = !occupied || (mag_reg < new_mag);
    assign mag = mag_reg;
    assign tag = tag_reg;

    always_comb
    begin
        mag_next = mag_reg;
        tag_next = tag_reg;
        if (ctl.load && lt)
        begin
            if (prev_lt)
            begin
                mag_next = prev_mag;
                tag_next = prev_tag;
            end
            else
            begin
                mag_next = new_mag;
                tag_next = new_tag;
            end
        end
        else if (ctl.shift)
        begin
            mag_next = next_mag;
            tag_next = next_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        tag_reg <= tag_next;
    end

endmodule

`default_nettype wire

// ===== design/tkms_ctrl.sv =====
// sequencer of the selector: config register, fill count, emission, result register
// depends on tkms_pkg, tkms_if and top_k_magnitude_selector_defines.svh
`default_nettype none
`include "top_k_magnitude_selector_defines.svh"

module tkms_ctrl import tkms_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int TAG_BITS = DEF_TAG_BITS,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    tkms_in_if.sink                    entry,
    tkms_out_if.source                 result,
    input  wire logic [MAG_W-1:0]      head_mag,
    input  wire logic [TAG_BITS-1:0]   head_tag,
    output cell_ctl_t                  cell_ctl,
    output logic      [CNT_W-1:0]      count
);

    typedef enum logic {ST_LOAD, ST_EMIT} state_t;

    state_t               state_reg, state_next;
    logic [TAKE_W-1:0]    take_reg, take_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic                 emit_ovf_reg, emit_ovf_next;
    logic [CNT_W-1:0]     remain_reg, remain_next;
    logic [RANK_W-1:0]    rank_reg, rank_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_TAG_W-1:0] out_tag_reg, out_tag_next;
    logic [MAG_W-1:0]     out_mag_reg, out_mag_next;
    logic [RANK_W-1:0]    out_rank_reg, out_rank_next;
    logic                 out_last_reg, out_last_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic              cfg_wr;
    logic              acc;
    logic              ins;
    logic              adv;
    logic [TAKE_W-1:0] limit;
    logic [CNT_W-1:0]  count_ins;
    logic [CNT_W-1:0]  n_emit;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TAKE_COUNT);
    assign prdata = (paddr[2] == REG_TAKE_COUNT) ? APB_DATA_W'(take_reg) : '0;

    assign entry.ready = (state_reg == ST_LOAD);
    assign acc         = entry.valid && entry.ready;
    assign ins         = acc && (count_reg < CNT_W'(CAPACITY));
    assign adv         = (state_reg == ST_EMIT) && (!out_valid_reg || result.ready);

    assign limit     = (take_reg == '0) ? TAKE_W'(1) : take_reg;
    assign count_ins = count_reg + CNT_W'(ins);
    assign n_emit    = (TAKE_W'(count_ins) < limit) ? count_ins : CNT_W'(limit);

    assign cell_ctl.load  = ins;
    assign cell_ctl.shift = adv;
    assign count          = count_reg;

    assign result.valid         = out_valid_reg;
    assign result.column_out    = out_tag_reg;
    assign result.magnitude_out = out_mag_reg;
    assign result.rank          = out_rank_reg;
    assign result.last_result   = out_last_reg;
    assign result.overflow      = out_ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        take_next      = cfg_wr ? pwdata[TAKE_W-1:0] : take_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        emit_ovf_next  = emit_ovf_reg;
        remain_next    = remain_reg;
        rank_next      = rank_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_tag_next   = out_tag_reg;
        out_mag_next   = out_mag_reg;
        out_rank_next  = out_rank_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (acc)
                begin
                    if (entry.last_entry)
                    begin
                        state_next    = ST_EMIT;
                        count_next    = '0;
                        dropped_next  = 1'b0;
                        emit_ovf_next = dropped_reg || !ins;
                        remain_next   = n_emit;
                        rank_next     = '0;
                    end
                    else
                    begin
                        count_next   = count_ins;
                        dropped_next = dropped_reg || !ins;
                    end
                end
            end
            ST_EMIT:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    out_tag_next   = OUT_TAG_W'(head_tag);
                    out_mag_next   = head_mag;
                    out_rank_next  = rank_reg;
                    out_last_next  = (remain_reg == CNT_W'(1));
                    out_ovf_next   = emit_ovf_reg;
                    remain_next    = remain_reg - CNT_W'(1);
                    rank_next      = rank_reg + RANK_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            take_reg      <= TAKE_RESET;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            emit_ovf_reg  <= 1'b0;
            remain_reg    <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            take_reg      <= take_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            emit_ovf_reg  <= emit_ovf_next;
            remain_reg    <= remain_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_tag_reg  <= out_tag_next;
        out_mag_reg  <= out_mag_next;
        out_rank_reg <= out_rank_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    `TKMS_ASSERT_IMPLY(a_load_not_full, clk, rst_n, cell_ctl.load, count_reg < CNT_W'(CAPACITY))
    `TKMS_ASSERT_IMPLY(a_no_load_shift, clk, rst_n, cell_ctl.shift, !cell_ctl.load && remain_reg != '0)
    `TKMS_ASSERT_NEXT(a_set_closes, clk, rst_n, acc && entry.last_entry, state_reg == ST_EMIT && count_reg == '0)
    `TKMS_ASSERT_NEXT(a_final_word, clk, rst_n, adv && remain_reg == CNT_W'(1), state_reg == ST_LOAD && out_last_reg)

endmodule

`default_nettype wire

// ===== design/top_k_magnitude_selector.sv =====
// top-k magnitude selector: entry channel in, ranked result words out
// depends on tkms_pkg, tkms_if, tkms_cell and tkms_ctrl
//
// usage:
//   entry words (magnitude, column_tag, last_entry) come in on a valid/ready channel.
//   each accepted word is placed into a sorted chain of CAPACITY cells as it is accepted,
//   so a set loads at one word per cycle. words past CAPACITY are dropped and flagged.
//   the word with last_entry closes the set; the chain then shifts its head into the
//   result register, one result word per cycle while the receiver takes them,
//   min(take_count, stored) words in descending order, ties in arrival order.
//   the first result word is valid from the clock edge after the one that accepts
//   the closing word, unless the previous set's last result word still waits.
//   entry ready is low during emission, while each word is emitted and while a
//   result word waits on the receiver; the last result register may still wait
//   while the next set loads.
//   take_count is written over the apb port at byte address 0 (zero acts as one).
//   reset empties the set, clears the drop flags and sets take_count to one.
//   a stalled receiver holds the result word and pauses the chain.
`default_nettype none

module top_k_magnitude_selector import tkms_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int TAG_BITS = DEF_TAG_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    tkms_in_if.sink                    entry,
    tkms_out_if.source                 result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_ctl_t           cell_ctl;
    logic [CNT_W-1:0]    count;
    logic [TAG_BITS-1:0] new_tag;
    logic                cell_lt  [CAPACITY];
    logic [MAG_W-1:0]    cell_mag [CAPACITY];
    logic [TAG_BITS-1:0] cell_tag [CAPACITY];

    assign new_tag = TAG_BITS'(entry.column_tag);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                prev_lt;
        logic [MAG_W-1:0]    prev_mag, next_mag;
        logic [TAG_BITS-1:0] prev_tag, next_tag;

        if (i == 0)
        begin : g_head
            assign prev_lt  = 1'b0;
            assign prev_mag = '0;
            assign prev_tag = '0;
        end
        else
        begin : g_body
            assign prev_lt  = cell_lt[i-1];
            assign prev_mag = cell_mag[i-1];
            assign prev_tag = cell_tag[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_mag = cell_mag[i];
            assign next_tag = cell_tag[i];
        end
        else
        begin : g_link
            assign next_mag = cell_mag[i+1];
            assign next_tag = cell_tag[i+1];
        end

        tkms_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk      (clk),
            .ctl      (cell_ctl),
            .occupied (CNT_W'(i) < count),
            .new_mag  (entry.magnitude),
            .new_tag  (new_tag),
            .prev_lt  (prev_lt),
            .prev_mag (prev_mag),
            .prev_tag (prev_tag),
            .next_mag (next_mag),
            .next_tag (next_tag),
            .lt       (cell_lt[i]),
            .mag      (cell_mag[i]),
            .tag      (cell_tag[i])
        );
    end

    tkms_ctrl #(
        .CAPACITY (CAPACITY),
        .TAG_BITS (TAG_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .entry    (entry),
        .result   (result),
        .head_mag (cell_mag[0]),
        .head_tag (cell_tag[0]),
        .cell_ctl (cell_ctl),
        .count    (count)
    );

endmodule

`default_nettype wire
